@@ sv/brl_pkg.sv @@
`default_nettype none
package brl_pkg;

   // Command codes on the request channel
   localparam int CMD_BITS = 1;
   localparam logic [CMD_BITS-1:0] CMD_START = 1'b0;
   localparam logic [CMD_BITS-1:0] CMD_STEP  = 1'b1;

   // Control register map
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 1'b1;

   // Resolution after reset
   localparam int SCREEN_WIDTH_RESET  = 640;
   localparam int SCREEN_HEIGHT_RESET = 480;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Classification of one command, produced by the front
   typedef struct packed {
      logic is_start;
      logic in_bounds;
      logic x_negative;
      logic y_negative;
   } brl_class_type;

endpackage
`default_nettype wire

@@ sv/brl_front.sv @@
`default_nettype none
module brl_front #(
   parameter int COORD_BITS = 11
) (
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [brl_pkg::CMD_BITS-1:0]      req_command,
   input  wire logic [COORD_BITS-1:0]             req_x_start,
   input  wire logic [COORD_BITS-1:0]             req_y_start,
   input  wire logic [COORD_BITS-1:0]             req_x_end,
   input  wire logic [COORD_BITS-1:0]             req_y_end,
   input  wire logic [COORD_BITS:0]               screen_width,
   input  wire logic [COORD_BITS:0]               screen_height,
   input  wire logic                              queue_full,
   output logic                                   queue_push,
   output brl_pkg::brl_class_type                 cls,
   output logic [COORD_BITS:0]                    delta_x,
   output logic [COORD_BITS:0]                    delta_y_negated
);
   import brl_pkg::*;

   logic              x_fwd;
   logic              y_fwd;
   logic [COORD_BITS:0] abs_dy;

   // Take a transaction whenever the queue has room
   assign req_ready  = !queue_full;
   assign queue_push = req_valid && !queue_full;

   // Classify the command and check both endpoints against the resolution
   assign x_fwd = req_x_start < req_x_end;
   assign y_fwd = req_y_start < req_y_end;

   always_comb begin
      cls.is_start   = (req_command == CMD_START);
      cls.in_bounds  = ({1'b0, req_x_start} < screen_width) &&
                       ({1'b0, req_x_end}   < screen_width) &&
                       ({1'b0, req_y_start} < screen_height) &&
                       ({1'b0, req_y_end}   < screen_height);
      cls.x_negative = !x_fwd;
      cls.y_negative = !y_fwd;
   end

   // Line deltas: |dx| and -|dy|
   assign delta_x = x_fwd ? ({1'b0, req_x_end} - {1'b0, req_x_start})
                          : ({1'b0, req_x_start} - {1'b0, req_x_end});
   assign abs_dy  = y_fwd ? ({1'b0, req_y_end} - {1'b0, req_y_start})
                          : ({1'b0, req_y_start} - {1'b0, req_y_end});
   assign delta_y_negated = (~abs_dy) + 1'b1;

endmodule
`default_nettype wire

@@ sv/brl_fifo.sv @@
`default_nettype none
module brl_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  head_valid,
   output logic [WIDTH-1:0]      head_data
);
   import brl_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff;
   logic [PW-1:0]    rd_ptr_in;
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    count_in;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

@@ sv/brl_back.sv @@
`default_nettype none
module brl_back #(
   parameter int COORD_BITS  = 11,
   parameter int COLOUR_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        head_valid,
   output logic                             head_pop,
   input  brl_pkg::brl_class_type           head_cls,
   input  wire logic [COORD_BITS-1:0]       head_x_start,
   input  wire logic [COORD_BITS-1:0]       head_y_start,
   input  wire logic [COORD_BITS-1:0]       head_x_end,
   input  wire logic [COORD_BITS-1:0]       head_y_end,
   input  wire logic [COLOUR_BITS-1:0]      head_colour,
   input  wire logic [COORD_BITS:0]         head_delta_x,
   input  wire logic [COORD_BITS:0]         head_delta_y_negated,
   input  wire logic [COORD_BITS:0]         screen_width,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [COORD_BITS-1:0]            rsp_pixel_x,
   output logic [COORD_BITS-1:0]            rsp_pixel_y,
   output logic [2*COORD_BITS-1:0]          rsp_pixel_address,
   output logic [COLOUR_BITS-1:0]           rsp_colour_out,
   output logic                             rsp_last_pixel
);
   import brl_pkg::*;

   localparam int AW = 2 * COORD_BITS;
   localparam int EW = COORD_BITS + 2;
   localparam int PW = 2 * COORD_BITS + 1;

   // Line state
   logic                   line_active_ff;
   logic [COORD_BITS-1:0]  cur_x_ff;
   logic [COORD_BITS-1:0]  cur_y_ff;
   logic [COORD_BITS-1:0]  tgt_x_ff;
   logic [COORD_BITS-1:0]  tgt_y_ff;
   logic [EW-1:0]          err_ff;
   logic [COORD_BITS:0]    dx_ff;
   logic [COORD_BITS:0]    dyn_ff;
   logic                   x_neg_ff;
   logic                   y_neg_ff;
   logic [COLOUR_BITS-1:0] colour_ff;

   // Product stage
   logic                   a_valid_ff;
   logic [COORD_BITS-1:0]  a_x_ff;
   logic [COORD_BITS-1:0]  a_y_ff;
   logic [AW-1:0]          a_prod_ff;
   logic [COLOUR_BITS-1:0] a_colour_ff;
   logic                   a_last_ff;

   // Output stage
   logic                   b_valid_ff;
   logic [COORD_BITS-1:0]  b_x_ff;
   logic [COORD_BITS-1:0]  b_y_ff;
   logic [AW-1:0]          b_addr_ff;
   logic [COLOUR_BITS-1:0] b_colour_ff;
   logic                   b_last_ff;

   logic                   b_ready;
   logic                   a_ready;
   logic                   emit;
   logic                   last;
   logic [EW:0]            e2;
   logic [EW:0]            dx_ext;
   logic [EW:0]            dyn_ext;
   logic                   move_x;
   logic                   move_y;
   logic [EW:0]            err_sum;
   logic [EW-1:0]          err_start;
   logic [PW-1:0]          prod_full;

   assign b_ready = !b_valid_ff || rsp_ready;
   assign a_ready = !a_valid_ff || b_ready;

   // Pop a start or idle step at once; hold a drawing step until the pipe has room
   assign emit     = !head_cls.is_start && line_active_ff;
   assign head_pop = head_valid && (!emit || a_ready);

   // Error walk for the next pixel
   assign last    = (cur_x_ff == tgt_x_ff) && (cur_y_ff == tgt_y_ff);
   assign e2      = {err_ff, 1'b0};
   assign dx_ext  = {2'b00, dx_ff};
   assign dyn_ext = {{2{dyn_ff[COORD_BITS]}}, dyn_ff};
   assign move_x  = $signed(e2) >= $signed(dyn_ext);
   assign move_y  = $signed(e2) <= $signed(dx_ext);
   assign err_sum = {err_ff[EW-1], err_ff} + (move_x ? dyn_ext : '0) + (move_y ? dx_ext : '0);
   assign err_start = {1'b0, head_delta_x} +
                      {head_delta_y_negated[COORD_BITS], head_delta_y_negated};

   always_ff @(posedge clock) begin
      if (reset) begin
         line_active_ff <= 1'b0;
      end else if (head_pop) begin
         if (head_cls.is_start) begin
            line_active_ff <= head_cls.in_bounds;
         end else if (line_active_ff && last) begin
            line_active_ff <= 1'b0;
         end
      end
   end

   // Load a new line or advance the current one
   always_ff @(posedge clock) begin
      if (head_pop) begin
         if (head_cls.is_start) begin
            if (head_cls.in_bounds) begin
               cur_x_ff  <= head_x_start;
               cur_y_ff  <= head_y_start;
               tgt_x_ff  <= head_x_end;
               tgt_y_ff  <= head_y_end;
               dx_ff     <= head_delta_x;
               dyn_ff    <= head_delta_y_negated;
               x_neg_ff  <= head_cls.x_negative;
               y_neg_ff  <= head_cls.y_negative;
               err_ff    <= err_start;
               colour_ff <= head_colour;
            end
         end else if (line_active_ff && !last) begin
            err_ff <= err_sum[EW-1:0];
            if (move_x) begin
               cur_x_ff <= x_neg_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
            end
            if (move_y) begin
               cur_y_ff <= y_neg_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;
            end
         end
      end
   end

   // Product stage: y times width
   assign prod_full = cur_y_ff * screen_width;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= head_pop && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && head_pop && emit) begin
         a_x_ff      <= cur_x_ff;
         a_y_ff      <= cur_y_ff;
         a_prod_ff   <= prod_full[AW-1:0];
         a_colour_ff <= colour_ff;
         a_last_ff   <= last;
      end
   end

   // Output stage: add x to form the address
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready && a_valid_ff) begin
         b_x_ff      <= a_x_ff;
         b_y_ff      <= a_y_ff;
         b_addr_ff   <= a_prod_ff + {{COORD_BITS{1'b0}}, a_x_ff};
         b_colour_ff <= a_colour_ff;
         b_last_ff   <= a_last_ff;
      end
   end

   assign rsp_valid         = b_valid_ff;
   assign rsp_pixel_x       = b_x_ff;
   assign rsp_pixel_y       = b_y_ff;
   assign rsp_pixel_address = b_addr_ff;
   assign rsp_colour_out    = b_colour_ff;
   assign rsp_last_pixel    = b_last_ff;

endmodule
`default_nettype wire

@@ sv/bresenham_line_rasterizer.sv @@
// Bresenham line rasterizer.
// Request channel (req_*): command START loads both endpoints and the colour;
// a line whose endpoint lies outside the programmed resolution is rejected and
// any line in progress is dropped. Command STEP emits one pixel of the active
// line on the response channel (rsp_*) and advances; a STEP with no active line
// emits nothing. rsp_last_pixel marks the end point, which ends the line.
// Control registers (csr_*): screen width and height, written while idle.
// Throughput: one transaction per cycle on both channels while the receiver does
// not stall. A STEP result passes the head of the two-entry command queue and
// the y*width product register; it is then presented from the output register
// where x is added.
// Reset empties the queue and pipe, ends any line and sets the resolution to
// 640 by 480. When the receiver stalls, the output and product registers hold
// their pixels, the back end stops popping drawing steps, and req_ready drops
// once the queue fills; START and idle STEP commands still drain meanwhile.
`default_nettype none
module bresenham_line_rasterizer #(
   parameter int COORD_BITS  = 11,
   parameter int COLOUR_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [brl_pkg::CMD_BITS-1:0]        req_command,
   input  wire logic [COORD_BITS-1:0]               req_x_start,
   input  wire logic [COORD_BITS-1:0]               req_y_start,
   input  wire logic [COORD_BITS-1:0]               req_x_end,
   input  wire logic [COORD_BITS-1:0]               req_y_end,
   input  wire logic [COLOUR_BITS-1:0]              req_pixel_colour,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [COORD_BITS-1:0]                    rsp_pixel_x,
   output logic [COORD_BITS-1:0]                    rsp_pixel_y,
   output logic [2*COORD_BITS-1:0]                  rsp_pixel_address,
   output logic [COLOUR_BITS-1:0]                   rsp_colour_out,
   output logic                                     rsp_last_pixel,
   input  wire logic                                csr_write_enable,
   input  wire logic [brl_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [COORD_BITS:0]                 csr_write_data
);
   import brl_pkg::*;

   localparam int RW = COORD_BITS + 1;
   localparam int CLS_BITS = $bits(brl_class_type);
   localparam int QW = CLS_BITS + 4 * COORD_BITS + COLOUR_BITS + 2 * RW;

   logic [RW-1:0]          screen_width_ff;
   logic [RW-1:0]          screen_height_ff;

   logic                   queue_full;
   logic                   queue_push;
   logic                   queue_pop;
   logic                   head_valid;
   logic [QW-1:0]          push_data;
   logic [QW-1:0]          head_data;

   brl_class_type          front_cls;
   logic [RW-1:0]          front_dx;
   logic [RW-1:0]          front_dyn;

   brl_class_type          head_cls;
   logic [COORD_BITS-1:0]  head_x_start;
   logic [COORD_BITS-1:0]  head_y_start;
   logic [COORD_BITS-1:0]  head_x_end;
   logic [COORD_BITS-1:0]  head_y_end;
   logic [COLOUR_BITS-1:0] head_colour;
   logic [RW-1:0]          head_dx;
   logic [RW-1:0]          head_dyn;

   // Resolution registers
   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= RW'(SCREEN_WIDTH_RESET);
         screen_height_ff <= RW'(SCREEN_HEIGHT_RESET);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_SCREEN_WIDTH:  screen_width_ff  <= csr_write_data;
            REG_SCREEN_HEIGHT: screen_height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   brl_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_x_start     (req_x_start),
      .req_y_start     (req_y_start),
      .req_x_end       (req_x_end),
      .req_y_end       (req_y_end),
      .screen_width    (screen_width_ff),
      .screen_height   (screen_height_ff),
      .queue_full      (queue_full),
      .queue_push      (queue_push),
      .cls             (front_cls),
      .delta_x         (front_dx),
      .delta_y_negated (front_dyn)
   );

   // Pack the classified command for the queue
   assign push_data = {front_cls, req_x_start, req_y_start, req_x_end, req_y_end,
                       req_pixel_colour, front_dx, front_dyn};

   brl_fifo #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (queue_pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   // Unpack the queue head
   assign {head_cls, head_x_start, head_y_start, head_x_end, head_y_end,
           head_colour, head_dx, head_dyn} = head_data;

   brl_back #(
      .COORD_BITS  (COORD_BITS),
      .COLOUR_BITS (COLOUR_BITS)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .head_valid           (head_valid),
      .head_pop             (queue_pop),
      .head_cls             (head_cls),
      .head_x_start         (head_x_start),
      .head_y_start         (head_y_start),
      .head_x_end           (head_x_end),
      .head_y_end           (head_y_end),
      .head_colour          (head_colour),
      .head_delta_x         (head_dx),
      .head_delta_y_negated (head_dyn),
      .screen_width         (screen_width_ff),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_pixel_x          (rsp_pixel_x),
      .rsp_pixel_y          (rsp_pixel_y),
      .rsp_pixel_address    (rsp_pixel_address),
      .rsp_colour_out       (rsp_colour_out),
      .rsp_last_pixel       (rsp_last_pixel)
   );

endmodule
`default_nettype wire

@@ tb/line_pixel_checker.sv @@
module line_pixel_checker #(
   parameter int COORD_BITS  = 11,
   parameter int COLOUR_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [brl_pkg::CMD_BITS-1:0]        req_command,
   input  logic [COORD_BITS-1:0]               req_x_start,
   input  logic [COORD_BITS-1:0]               req_y_start,
   input  logic [COORD_BITS-1:0]               req_x_end,
   input  logic [COORD_BITS-1:0]               req_y_end,
   input  logic [COLOUR_BITS-1:0]              req_pixel_colour,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [COORD_BITS-1:0]               rsp_pixel_x,
   input  logic [COORD_BITS-1:0]               rsp_pixel_y,
   input  logic [2*COORD_BITS-1:0]             rsp_pixel_address,
   input  logic [COLOUR_BITS-1:0]              rsp_colour_out,
   input  logic                                rsp_last_pixel,
   input  logic                                csr_write_enable,
   input  logic [brl_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [COORD_BITS:0]                 csr_write_data,
   output int                                  mismatch_count,
   output int                                  pixels_pending
);

   typedef struct packed {
      logic [COORD_BITS-1:0]   x;
      logic [COORD_BITS-1:0]   y;
      logic [2*COORD_BITS-1:0] address;
      logic [COLOUR_BITS-1:0]  colour;
      logic                    is_last;
   } pixel_type;

   pixel_type expected_pixels[$];
   int        errors_seen;

   // Shadow of the resolution registers and of the line walker
   logic [COORD_BITS:0]          screen_width;
   logic [COORD_BITS:0]          screen_height;
   logic [COORD_BITS-1:0]        pen_x;
   logic [COORD_BITS-1:0]        pen_y;
   logic [COORD_BITS-1:0]        end_x;
   logic [COORD_BITS-1:0]        end_y;
   logic signed [COORD_BITS+1:0] walk_error;
   logic signed [COORD_BITS:0]   span_x;
   logic signed [COORD_BITS:0]   span_y_neg;
   logic                         x_down;
   logic                         y_down;
   logic                         line_open;
   logic [COLOUR_BITS-1:0]       line_colour;

   task automatic clear_walker();
      screen_width  = (COORD_BITS+1)'(brl_pkg::SCREEN_WIDTH_RESET);
      screen_height = (COORD_BITS+1)'(brl_pkg::SCREEN_HEIGHT_RESET);
      pen_x       = '0;
      pen_y       = '0;
      end_x       = '0;
      end_y       = '0;
      walk_error  = '0;
      span_x      = '0;
      span_y_neg  = '0;
      x_down      = 1'b0;
      y_down      = 1'b0;
      line_open   = 1'b0;
      line_colour = '0;
      expected_pixels.delete();
   endtask

   // Load a line on START; on STEP emit the current pixel and walk one step
   task automatic plot_command(
      input logic [brl_pkg::CMD_BITS-1:0] command,
      input logic [COORD_BITS-1:0]        xs,
      input logic [COORD_BITS-1:0]        ys,
      input logic [COORD_BITS-1:0]        xe,
      input logic [COORD_BITS-1:0]        ye,
      input logic [COLOUR_BITS-1:0]       colour
   );
      pixel_type                    px;
      logic                         fits;
      logic [COORD_BITS-1:0]        rise;
      logic signed [COORD_BITS+2:0] doubled;
      if (command == brl_pkg::CMD_START) begin
         fits = xs < screen_width && xe < screen_width &&
                ys < screen_height && ye < screen_height;
         line_open = fits;
         if (fits) begin
            pen_x       = xs;
            pen_y       = ys;
            end_x       = xe;
            end_y       = ye;
            x_down      = !(xs < xe);
            y_down      = !(ys < ye);
            span_x      = (xs < xe) ? xe - xs : xs - xe;
            rise        = (ys < ye) ? ye - ys : ys - ye;
            span_y_neg  = -$signed({1'b0, rise});
            walk_error  = span_x + span_y_neg;
            line_colour = colour;
         end
      end else if (line_open) begin
         px.x       = pen_x;
         px.y       = pen_y;
         px.address = pen_x + pen_y * screen_width;
         px.colour  = line_colour;
         px.is_last = (pen_x == end_x) && (pen_y == end_y);
         expected_pixels.push_back(px);
         if (px.is_last) begin
            line_open = 1'b0;
         end else begin
            doubled = {walk_error, 1'b0};
            if (doubled >= span_y_neg) begin
               walk_error = walk_error + span_y_neg;
               pen_x      = x_down ? pen_x - 1'b1 : pen_x + 1'b1;
            end
            if (doubled <= span_x) begin
               walk_error = walk_error + span_x;
               pen_y      = y_down ? pen_y - 1'b1 : pen_y + 1'b1;
            end
         end
      end
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         errors_seen++;
      end
   endtask

   // Compare one pixel transaction against the oldest prediction
   task automatic compare_pixel();
      pixel_type px;
      if (expected_pixels.size() == 0) begin
         $error("pixel at x %0d y %0d with no pending prediction", rsp_pixel_x, rsp_pixel_y);
         errors_seen++;
      end else begin
         px = expected_pixels.pop_front();
         check_field("pixel_x", px.x, rsp_pixel_x);
         check_field("pixel_y", px.y, rsp_pixel_y);
         check_field("pixel_address", px.address, rsp_pixel_address);
         check_field("colour_out", px.colour, rsp_colour_out);
         check_field("last_pixel", px.is_last, rsp_last_pixel);
      end
   endtask

   // Track register writes, predict on requests, check on responses
   always @(posedge clock) begin
      if (reset) begin
         clear_walker();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == brl_pkg::REG_SCREEN_WIDTH) begin
               screen_width = csr_write_data;
            end else if (csr_index == brl_pkg::REG_SCREEN_HEIGHT) begin
               screen_height = csr_write_data;
            end
         end
         if (req_valid && req_ready) begin
            plot_command(req_command, req_x_start, req_y_start, req_x_end, req_y_end,
                         req_pixel_colour);
         end
         if (rsp_valid && rsp_ready) begin
            compare_pixel();
         end
      end
      mismatch_count <= errors_seen;
      pixels_pending <= expected_pixels.size();
   end

endmodule

@@ tb/testbench.sv @@
module testbench;

   localparam int COORD_BITS  = 11;
   localparam int COLOUR_BITS = 16;
   localparam int COORD_LIMIT = 1 << COORD_BITS;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic [brl_pkg::CMD_BITS-1:0]        req_command;
   logic [COORD_BITS-1:0]               req_x_start;
   logic [COORD_BITS-1:0]               req_y_start;
   logic [COORD_BITS-1:0]               req_x_end;
   logic [COORD_BITS-1:0]               req_y_end;
   logic [COLOUR_BITS-1:0]              req_pixel_colour;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic [COORD_BITS-1:0]               rsp_pixel_x;
   logic [COORD_BITS-1:0]               rsp_pixel_y;
   logic [2*COORD_BITS-1:0]             rsp_pixel_address;
   logic [COLOUR_BITS-1:0]              rsp_colour_out;
   logic                                rsp_last_pixel;
   logic                                csr_write_enable;
   logic [brl_pkg::CSR_INDEX_BITS-1:0]  csr_index;
   logic [COORD_BITS:0]                 csr_write_data;
   int                                  mismatch_count;
   int                                  pixels_pending;

   int res_x;
   int res_y;
   int items_sent;
   bit gaps_on;

   bresenham_line_rasterizer #(
      .COORD_BITS  (COORD_BITS),
      .COLOUR_BITS (COLOUR_BITS)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_x_start       (req_x_start),
      .req_y_start       (req_y_start),
      .req_x_end         (req_x_end),
      .req_y_end         (req_y_end),
      .req_pixel_colour  (req_pixel_colour),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_x       (rsp_pixel_x),
      .rsp_pixel_y       (rsp_pixel_y),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_colour_out    (rsp_colour_out),
      .rsp_last_pixel    (rsp_last_pixel),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   line_pixel_checker #(
      .COORD_BITS  (COORD_BITS),
      .COLOUR_BITS (COLOUR_BITS)
   ) i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_x_start       (req_x_start),
      .req_y_start       (req_y_start),
      .req_x_end         (req_x_end),
      .req_y_end         (req_y_end),
      .req_pixel_colour  (req_pixel_colour),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_x       (rsp_pixel_x),
      .rsp_pixel_y       (rsp_pixel_y),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_colour_out    (rsp_colour_out),
      .rsp_last_pixel    (rsp_last_pixel),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .mismatch_count    (mismatch_count),
      .pixels_pending    (pixels_pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Favor the edges of the screen now and then
   function automatic int pick_coord(input int limit);
      int roll;
      roll = $urandom_range(0, 7);
      if (roll == 0) return 0;
      if (roll == 1) return limit - 1;
      return $urandom_range(0, limit - 1);
   endfunction

   function automatic int near_coord(input int base, input int limit, input int reach);
      int pos;
      pos = base + $urandom_range(0, 2 * reach) - reach;
      if (pos < 0) return 0;
      if (pos > limit - 1) return limit - 1;
      return pos;
   endfunction

   // Present one request and hold it until accepted
   task automatic issue_command(
      input logic [brl_pkg::CMD_BITS-1:0] command,
      input int                           xs,
      input int                           ys,
      input int                           xe,
      input int                           ye,
      input int                           colour
   );
      int gap;
      gap = gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_command      <= command;
      req_x_start      <= COORD_BITS'(xs);
      req_y_start      <= COORD_BITS'(ys);
      req_x_end        <= COORD_BITS'(xe);
      req_y_end        <= COORD_BITS'(ye);
      req_pixel_colour <= COLOUR_BITS'(colour);
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Step commands carry junk in the unused fields
   task automatic step_pen(input int count);
      repeat (count) begin
         issue_command(brl_pkg::CMD_STEP, $urandom_range(0, COORD_LIMIT - 1),
                       $urandom_range(0, COORD_LIMIT - 1), $urandom_range(0, COORD_LIMIT - 1),
                       $urandom_range(0, COORD_LIMIT - 1), $urandom_range(0, 65535));
      end
   endtask

   // Drop valid, wait for every predicted pixel, then let the pipe settle
   task automatic drain_pipeline();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pixels_pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_register(input logic [brl_pkg::CSR_INDEX_BITS-1:0] index,
                                 input int value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= (COORD_BITS+1)'(value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_resolution(input int width, input int height);
      drain_pipeline();
      write_register(brl_pkg::REG_SCREEN_WIDTH, width);
      write_register(brl_pkg::REG_SCREEN_HEIGHT, height);
      res_x = width;
      res_y = height;
   endtask

   // One well-formed line: in-bounds endpoints, mostly short, usually stepped to its end
   task automatic draw_random_line();
      int x_lim, y_lim, xs, ys, xe, ye, reach, length, steps;
      x_lim  = (res_x > COORD_LIMIT) ? COORD_LIMIT : res_x;
      y_lim  = (res_y > COORD_LIMIT) ? COORD_LIMIT : res_y;
      reach  = ($urandom_range(0, 19) == 0) ? 300 : 12;
      xs     = pick_coord(x_lim);
      ys     = pick_coord(y_lim);
      xe     = near_coord(xs, x_lim, reach);
      ye     = near_coord(ys, y_lim, reach);
      length = ((xe > xs) ? xe - xs : xs - xe);
      if (((ye > ys) ? ye - ys : ys - ye) > length) length = (ye > ys) ? ye - ys : ys - ye;
      length = length + 1;
      steps  = length + $urandom_range(0, 2);
      // Cut some lines short so the next start drops them
      if ($urandom_range(0, 9) == 0) steps = $urandom_range(0, length - 1);
      issue_command(brl_pkg::CMD_START, xs, ys, xe, ye, $urandom_range(0, 65535));
      step_pen(steps);
   endtask

   task automatic run_random_phase(input int quota);
      int first;
      int roll;
      first = items_sent;
      while (items_sent - first < quota) begin
         roll = $urandom_range(0, 99);
         if (roll < 78) begin
            draw_random_line();
         end else if (roll < 88) begin
            // Arbitrary endpoints, rejected unless they fit the resolution
            issue_command(brl_pkg::CMD_START, $urandom_range(0, COORD_LIMIT - 1),
                          $urandom_range(0, COORD_LIMIT - 1), $urandom_range(0, COORD_LIMIT - 1),
                          $urandom_range(0, COORD_LIMIT - 1), $urandom_range(0, 65535));
         end else begin
            step_pen($urandom_range(1, 4));
         end
      end
   endtask

   // Result side: stretches without stalls, light and heavy stalls, long holds
   initial begin
      int run_len;
      int style;
      rsp_ready = 1'b0;
      forever begin
         run_len = $urandom_range(1, 40);
         style   = $urandom_range(0, 9);
         repeat (run_len) begin
            @(negedge clock);
            if (style < 4) rsp_ready <= 1'b1;
            else if (style < 7) rsp_ready <= ($urandom_range(0, 3) != 0);
            else if (style < 9) rsp_ready <= $urandom_range(0, 1);
            else rsp_ready <= 1'b0;
         end
      end
   end

   initial begin
      #(12 * 1000000);
      $display("Verification failed");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_command      = brl_pkg::CMD_START;
      req_x_start      = '0;
      req_y_start      = '0;
      req_x_end        = '0;
      req_y_end        = '0;
      req_pixel_colour = '0;
      csr_write_enable = 1'b0;
      csr_index        = brl_pkg::REG_SCREEN_WIDTH;
      csr_write_data   = '0;
      res_x            = brl_pkg::SCREEN_WIDTH_RESET;
      res_y            = brl_pkg::SCREEN_HEIGHT_RESET;
      items_sent       = 0;
      gaps_on          = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Step with no line, then a short shallow line run past its end
      step_pen(1);
      issue_command(brl_pkg::CMD_START, 0, 0, 3, 1, 'hFFFF);
      step_pen(5);
      // Reverse line from the far corner, abandoned by a start out of x range
      issue_command(brl_pkg::CMD_START, 639, 479, 636, 477, 'h0000);
      step_pen(2);
      issue_command(brl_pkg::CMD_START, 10, 10, 640, 10, 'h5A5A);
      step_pen(1);
      // Start out of y range, then a single-point line
      issue_command(brl_pkg::CMD_START, 10, 10, 20, 480, 'hA5A5);
      issue_command(brl_pkg::CMD_START, 5, 5, 5, 5, 'h1234);
      step_pen(1);
      // Leave a steep line open across a width change
      issue_command(brl_pkg::CMD_START, 20, 10, 18, 14, 'h0F0F);
      step_pen(2);
      set_resolution(4095, 4095);
      step_pen(4);
      // Top coordinates, address wraps
      issue_command(brl_pkg::CMD_START, 2047, 2047, 2045, 2046, 'hF0F0);
      step_pen(3);
      // Zero resolution rejects everything; one-pixel screen takes the origin
      set_resolution(0, 0);
      issue_command(brl_pkg::CMD_START, 0, 0, 0, 0, 'h00FF);
      step_pen(1);
      set_resolution(1, 1);
      issue_command(brl_pkg::CMD_START, 0, 0, 0, 0, 'hFF00);
      step_pen(1);

      // Random phases over a spread of resolutions
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: set_resolution(640, 480);
            1: set_resolution(2048, 2048);
            2: set_resolution(4095, 4095);
            3: set_resolution(1, 5);
            4: set_resolution(16, 2048);
            5: set_resolution(2047, 3);
            default: set_resolution($urandom_range(1, 4095), $urandom_range(1, 4095));
         endcase
         gaps_on = ($urandom_range(0, 3) != 0);
         run_random_phase(125);
      end

      drain_pipeline();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && pixels_pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
